/* src/bspline_basis_eval_assert.svh */
// ----------------------------------------------------------------------------
// bspline basis evaluator assertion macros
// concurrent checks that compile away when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef BSPLINE_BASIS_EVAL_ASSERT_SVH
`define BSPLINE_BASIS_EVAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define BSBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bspline basis check failed");
`define BSBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bspline basis check failed");
`else
`define BSBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/bsbe_pkg.sv */
// ----------------------------------------------------------------------------
// bsbe_pkg
// shared types and constants of the bspline basis evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package bsbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int IDX_W     = 6;
    localparam int DEG_W     = 3;
    localparam int CNT_W     = 6;
    localparam int ORD_W     = 4;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int DEG_SLOTS = 8;

    localparam logic [VAL_W-1:0] ONE_FX = VAL_W'(1) << FRAC_BITS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINTS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER       = 1'b1;

    localparam logic [CNT_W-1:0] CTRL_POINTS_RST = 6'd10;
    localparam logic [ORD_W-1:0] ORDER_RST       = 4'd4;

    typedef struct packed {
        logic [VAL_W-1:0] param_u;
        logic [IDX_W-1:0] basis_index;
        logic [DEG_W-1:0] basis_degree;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] basis_value;
        logic             range_error;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [VAL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

/* src/bsbe_div.sv */
// ----------------------------------------------------------------------------
// bsbe_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bsbe_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bsbe_pkg::div_req_t req,
    output bsbe_pkg::div_rsp_t      rsp
);

    localparam int CW = $clog2(bsbe_pkg::PROD_W + 1);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [bsbe_pkg::VAL_W-1:0]    rem_reg, rem_next;
    logic [bsbe_pkg::PROD_W-1:0]   quo_reg, quo_next;
    logic [bsbe_pkg::VAL_W-1:0]    dvs_reg, dvs_next;
    logic [bsbe_pkg::VAL_W:0]      trial;
    logic [bsbe_pkg::VAL_W:0]      diff;
    logic                          ge;

    assign trial = {rem_reg, quo_reg[bsbe_pkg::PROD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            // a new start reloads, dropping any division in flight
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[bsbe_pkg::VAL_W-1:0] : trial[bsbe_pkg::VAL_W-1:0];
            quo_next = {quo_reg[bsbe_pkg::PROD_W-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(bsbe_pkg::PROD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

/* src/bsbe_knot_ram.sv */
// ----------------------------------------------------------------------------
// bsbe_knot_ram
// single-port knot table with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bsbe_knot_ram #(
    parameter int DEPTH = 40,
    parameter int AW    = 6
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              addr,
    input  wire logic [bsbe_pkg::VAL_W-1:0] wdata,
    output logic [bsbe_pkg::VAL_W-1:0]      rdata
);

    logic [bsbe_pkg::VAL_W-1:0] mem [DEPTH];
    logic [bsbe_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/bspline_basis_eval.sv */
// ----------------------------------------------------------------------------
// bspline_basis_eval
// evaluates one B-spline basis value N(i,p)(u) per command over a clamped
// uniform knot table held in a single-port memory
//
// a command (cmd) is taken when start is high and busy is low. the result
// appears on result with done high for exactly one cycle; result keeps it
// until the next result. an index that runs past the knot table answers in
// the cycle right after start with range_error set and a zero value.
// otherwise the block runs degree 0 through D0_A, D0_B and D0_C per span,
// then for each of the p*(p+1)/2 recursion terms reads four knots (R_A to
// R_E) and sends every nonzero partial term (at most two per term) through
// the shared divider, and aligns the table once per degree level. the
// divider and the one memory read port set the run time.
// configuration writes (cfg_we, cfg_index, cfg_data) rebuild the knot table:
// one entry per cycle, except that each of the n-k interior knots waits for
// the divider. reset starts the same rebuild for the reset configuration;
// busy stays high until it ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bspline_basis_eval_assert.svh"

module bspline_basis_eval #(
    parameter int MAX_POINTS = 32,
    parameter int MAX_ORDER  = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire bsbe_pkg::cmd_t                 cmd,
    output logic                                done,
    output bsbe_pkg::result_t                   result,
    input  wire logic                           cfg_we,
    input  wire logic [bsbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsbe_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_POINTS + MAX_ORDER;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = (AW > 7) ? AW + 1 : 8;
    localparam int VW    = bsbe_pkg::VAL_W;
    localparam int PW    = bsbe_pkg::PROD_W;
    localparam int DW    = bsbe_pkg::DEG_W;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RB_EVAL = 5'd1;
    localparam logic [4:0] ST_RB_WAIT = 5'd2;
    localparam logic [4:0] ST_D0_A    = 5'd3;
    localparam logic [4:0] ST_D0_B    = 5'd4;
    localparam logic [4:0] ST_D0_C    = 5'd5;
    localparam logic [4:0] ST_R_A     = 5'd6;
    localparam logic [4:0] ST_R_B     = 5'd7;
    localparam logic [4:0] ST_R_C     = 5'd8;
    localparam logic [4:0] ST_R_D     = 5'd9;
    localparam logic [4:0] ST_R_E     = 5'd10;
    localparam logic [4:0] ST_R_LGO   = 5'd11;
    localparam logic [4:0] ST_R_LWAIT = 5'd12;
    localparam logic [4:0] ST_R_RPREP = 5'd13;
    localparam logic [4:0] ST_R_RGO   = 5'd14;
    localparam logic [4:0] ST_R_RWAIT = 5'd15;
    localparam logic [4:0] ST_R_SAVE  = 5'd16;
    localparam logic [4:0] ST_R_ALIGN = 5'd17;

    logic [4:0]                  state_reg, state_next;
    logic [bsbe_pkg::CNT_W-1:0]  npts_reg, npts_next;
    logic [bsbe_pkg::ORD_W-1:0]  ord_reg, ord_next;
    logic [AW-1:0]               rbx_reg, rbx_next;
    logic [VW-1:0]               u_reg, u_next;
    logic [bsbe_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [DW-1:0]               p_reg, p_next;
    logic [DW-1:0]               j_reg, j_next;
    logic [DW-1:0]               q_reg, q_next;
    logic [VW-1:0]               ka_reg, ka_next;
    logic [VW-1:0]               kb_reg, kb_next;
    logic [VW-1:0]               kc_reg, kc_next;
    logic [VW-1:0]               kd_reg, kd_next;
    logic [PW-1:0]               prod_reg, prod_next;
    logic [VW-1:0]               den_reg, den_next;
    logic                        zero_reg, zero_next;
    logic [VW:0]                 acc_reg, acc_next;
    logic [VW-1:0]               tab_reg [bsbe_pkg::DEG_SLOTS];
    logic [VW-1:0]               tab_next [bsbe_pkg::DEG_SLOTS];
    logic                        done_reg, done_next;
    bsbe_pkg::result_t           result_reg, result_next;

    logic [IW-1:0]               n_eff, k_eff, len, dsp, x_ext, rb_j, s_idx, addr_full;
    logic [IW-1:0]               req_top;
    logic [PW-1:0]               rb_dividend;
    logic [VW-1:0]               mul_a, mul_b;
    logic [PW-1:0]               mul_p;
    logic [VW-1:0]               q_sat;
    logic [VW:0]                 acc_sum;
    logic [VW-1:0]               new_val;
    logic [DW-1:0]               wpos;
    logic                        hit;
    logic                        ram_we;
    logic [VW-1:0]               ram_wdata, ram_rdata;
    bsbe_pkg::div_req_t          div_req;
    bsbe_pkg::div_rsp_t          div_rsp;

    // effective configuration after clamping
    always_comb
    begin
        n_eff = IW'(npts_reg);
        if (npts_reg < bsbe_pkg::CNT_W'(2))
        begin
            n_eff = IW'(2);
        end
        else if (IW'(npts_reg) > IW'(MAX_POINTS))
        begin
            n_eff = IW'(MAX_POINTS);
        end
        k_eff = IW'(ord_reg);
        if (ord_reg == '0)
        begin
            k_eff = IW'(1);
        end
        else if (IW'(ord_reg) > IW'(MAX_ORDER))
        begin
            k_eff = IW'(MAX_ORDER);
        end
        if (k_eff > n_eff)
        begin
            k_eff = n_eff;
        end
    end

    assign len         = n_eff + k_eff;
    assign dsp         = n_eff - k_eff + IW'(1);
    assign x_ext       = IW'(rbx_reg);
    assign rb_j        = x_ext - k_eff + IW'(1);
    assign rb_dividend = (PW'(rb_j) << bsbe_pkg::FRAC_BITS) + PW'(dsp >> 1);
    assign s_idx       = IW'(i_reg) + IW'(j_reg);
    assign req_top     = IW'(cmd.basis_index) + IW'(cmd.basis_degree) + IW'(1);
    assign wpos        = p_reg - q_reg + DW'(1);

    assign mul_p   = mul_a * mul_b;
    assign q_sat   = (div_rsp.quotient > PW'(bsbe_pkg::ONE_FX)) ? bsbe_pkg::ONE_FX
                                                             : div_rsp.quotient[VW-1:0];
    assign acc_sum = acc_reg + {1'b0, q_sat};
    assign new_val = (acc_reg > {1'b0, bsbe_pkg::ONE_FX}) ? bsbe_pkg::ONE_FX
                                                          : acc_reg[VW-1:0];
    // degree zero span test, u = 1.0 lands in the last non-empty span
    assign hit = ((ka_reg <= u_reg) && (u_reg < ram_rdata))
              || ((u_reg == bsbe_pkg::ONE_FX) && (s_idx == n_eff - IW'(1)));

    always_comb
    begin
        case (state_reg)
            ST_D0_B: addr_full = s_idx + IW'(1);
            ST_R_B:  addr_full = s_idx + IW'(q_reg);
            ST_R_C:  addr_full = s_idx + IW'(1);
            ST_R_D:  addr_full = s_idx + IW'(q_reg) + IW'(1);
            ST_RB_EVAL, ST_RB_WAIT: addr_full = x_ext;
            default: addr_full = s_idx;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        npts_next   = npts_reg;
        ord_next    = ord_reg;
        rbx_next    = rbx_reg;
        u_next      = u_reg;
        i_next      = i_reg;
        p_next      = p_reg;
        j_next      = j_reg;
        q_next      = q_reg;
        ka_next     = ka_reg;
        kb_next     = kb_reg;
        kc_next     = kc_reg;
        kd_next     = kd_reg;
        prod_next   = prod_reg;
        den_next    = den_reg;
        zero_next   = zero_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        for (int t = 0; t < bsbe_pkg::DEG_SLOTS; t++)
        begin
            tab_next[t] = tab_reg[t];
        end
        mul_a            = u_reg - ka_reg;
        mul_b            = tab_reg[0];
        ram_we           = 1'b0;
        ram_wdata        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = den_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    u_next = (cmd.param_u > bsbe_pkg::ONE_FX) ? bsbe_pkg::ONE_FX
                                                              : cmd.param_u;
                    i_next = cmd.basis_index;
                    p_next = cmd.basis_degree;
                    j_next = '0;
                    if (req_top >= len)
                    begin
                        result_next.basis_value = '0;
                        result_next.range_error = 1'b1;
                        done_next               = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_D0_A;
                    end
                end
            end

            ST_RB_EVAL:
            begin
                if (x_ext < k_eff)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                end
                else if (x_ext >= n_eff)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = bsbe_pkg::ONE_FX;
                end
                else
                begin
                    // interior knot: rounded j / d through the divider
                    div_req.start    = 1'b1;
                    div_req.dividend = rb_dividend;
                    div_req.divisor  = VW'(dsp);
                end
                if ((x_ext >= k_eff) && (x_ext < n_eff))
                begin
                    state_next = ST_RB_WAIT;
                end
                else if (rbx_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rbx_next = rbx_reg + AW'(1);
                end
            end

            ST_RB_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = div_rsp.quotient[VW-1:0];
                    if (rbx_reg == AW'(DEPTH - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rbx_next   = rbx_reg + AW'(1);
                        state_next = ST_RB_EVAL;
                    end
                end
            end

            ST_D0_A: state_next = ST_D0_B;

            ST_D0_B:
            begin
                ka_next    = ram_rdata;
                state_next = ST_D0_C;
            end

            ST_D0_C:
            begin
                tab_next[j_reg] = hit ? bsbe_pkg::ONE_FX : '0;
                if (j_reg == p_reg)
                begin
                    if (p_reg == '0)
                    begin
                        result_next.basis_value = hit ? bsbe_pkg::ONE_FX : '0;
                        result_next.range_error = 1'b0;
                        done_next               = 1'b1;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        q_next     = DW'(1);
                        j_next     = '0;
                        state_next = ST_R_A;
                    end
                end
                else
                begin
                    j_next     = j_reg + DW'(1);
                    state_next = ST_D0_A;
                end
            end

            ST_R_A: state_next = ST_R_B;

            ST_R_B:
            begin
                ka_next    = ram_rdata;
                state_next = ST_R_C;
            end

            ST_R_C:
            begin
                kb_next    = ram_rdata;
                state_next = ST_R_D;
            end

            ST_R_D:
            begin
                kc_next    = ram_rdata;
                state_next = ST_R_E;
            end

            ST_R_E:
            begin
                // left term: (u - k[s]) * N(s) / (k[s+q] - k[s])
                kd_next    = ram_rdata;
                mul_a      = u_reg - ka_reg;
                mul_b      = tab_reg[0];
                prod_next  = mul_p;
                den_next   = kb_reg - ka_reg;
                zero_next  = (u_reg <= ka_reg) || (kb_reg <= ka_reg) || (tab_reg[0] == '0);
                state_next = ST_R_LGO;
            end

            ST_R_LGO:
            begin
                acc_next = '0;
                if (zero_reg)
                begin
                    state_next = ST_R_RPREP;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_R_LWAIT;
                end
            end

            ST_R_LWAIT:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = {1'b0, q_sat};
                    state_next = ST_R_RPREP;
                end
            end

            ST_R_RPREP:
            begin
                // right term: (k[s+q+1] - u) * N(s+1) / (k[s+q+1] - k[s+1])
                mul_a      = kd_reg - u_reg;
                mul_b      = tab_reg[1];
                prod_next  = mul_p;
                den_next   = kd_reg - kc_reg;
                zero_next  = (kd_reg <= u_reg) || (kd_reg <= kc_reg) || (tab_reg[1] == '0);
                state_next = ST_R_RGO;
            end

            ST_R_RGO:
            begin
                if (zero_reg)
                begin
                    state_next = ST_R_SAVE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_R_RWAIT;
                end
            end

            ST_R_RWAIT:
            begin
                if (div_rsp.done)
                begin
                    acc_next   = acc_sum;
                    state_next = ST_R_SAVE;
                end
            end

            ST_R_SAVE:
            begin
                // slide the row down, new value goes behind the live entries
                for (int t = 0; t < bsbe_pkg::DEG_SLOTS - 1; t++)
                begin
                    tab_next[t] = tab_reg[t+1];
                end
                tab_next[bsbe_pkg::DEG_SLOTS-1] = '0;
                tab_next[wpos] = new_val;
                if (j_reg == p_reg - q_reg)
                begin
                    state_next = ST_R_ALIGN;
                end
                else
                begin
                    j_next     = j_reg + DW'(1);
                    state_next = ST_R_A;
                end
            end

            ST_R_ALIGN:
            begin
                for (int t = 0; t < bsbe_pkg::DEG_SLOTS - 1; t++)
                begin
                    tab_next[t] = tab_reg[t+1];
                end
                tab_next[bsbe_pkg::DEG_SLOTS-1] = '0;
                if (q_reg == p_reg)
                begin
                    result_next.basis_value = tab_reg[1];
                    result_next.range_error = 1'b0;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    q_next     = q_reg + DW'(1);
                    j_next     = '0;
                    state_next = ST_R_A;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // a register write rebuilds the table from the first entry
        if (cfg_we)
        begin
            case (cfg_index)
                bsbe_pkg::REG_CTRL_POINTS: npts_next = cfg_data;
                bsbe_pkg::REG_ORDER:       ord_next  = cfg_data[bsbe_pkg::ORD_W-1:0];
                default:                   npts_next = npts_reg;
            endcase
            rbx_next   = '0;
            state_next = ST_RB_EVAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RB_EVAL;
            npts_reg  <= bsbe_pkg::CTRL_POINTS_RST;
            ord_reg   <= bsbe_pkg::ORDER_RST;
            rbx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            npts_reg  <= npts_next;
            ord_reg   <= ord_next;
            rbx_reg   <= rbx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        i_reg      <= i_next;
        p_reg      <= p_next;
        j_reg      <= j_next;
        q_reg      <= q_next;
        ka_reg     <= ka_next;
        kb_reg     <= kb_next;
        kc_reg     <= kc_next;
        kd_reg     <= kd_next;
        prod_reg   <= prod_next;
        den_reg    <= den_next;
        zero_reg   <= zero_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        for (int t = 0; t < bsbe_pkg::DEG_SLOTS; t++)
        begin
            tab_reg[t] <= tab_next[t];
        end
    end

    bsbe_knot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_knot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_full[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bsbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `BSBE_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `BSBE_ASSERT_NXT(a_start_moves, clk, rst_n, start && !busy, busy || done)
    `BSBE_ASSERT_IMP(a_err_zero, clk, rst_n, done && result.range_error, result.basis_value == '0)

endmodule

`default_nettype wire
